// ===== src/mcema_pkg.sv =====
// Shared types, constants and the shift-code lookup for the multichannel EMA filter.
// No dependencies; used by every module under src.
package mcema_pkg;

  localparam int ChanW         = 5;
  localparam int SampleW       = 12;
  localparam int ResW          = 5;
  localparam int KW            = 3;
  localparam int AccW          = 17;
  localparam int ShiftTableW   = 51;
  localparam int TableChannels = ShiftTableW / KW;

  localparam logic [ShiftTableW-1:0] ShiftTableReset = 51'd321685687669321;

  localparam logic [KW-1:0] MinShift     = 3'd1;
  localparam logic [KW-1:0] MaxShift     = 3'd5;
  localparam logic [KW-1:0] DefaultShift = 3'd1;

  // State write-back from the update logic into the state bank
  typedef struct packed {
    logic               we;
    logic [ChanW-1:0]   ch;
    logic [SampleW-1:0] y;
    logic [ResW-1:0]    res;
  } state_wr_t;

  // Read data from the state bank for one channel
  typedef struct packed {
    logic [SampleW-1:0] y;
    logic [ResW-1:0]    res;
  } state_rd_t;

  // Effective shift of a channel; codes outside 1..5 and channels past the table act as 1
  function automatic logic [KW-1:0] shift_of(logic [ShiftTableW-1:0] tbl,
                                             logic [ChanW-1:0] ch);
    logic [KW-1:0] code;
    code = '0;
    for (int n = 0; n < TableChannels; n++) begin
      if (ch == ChanW'(n)) code = tbl[KW*n +: KW];
    end
    if (code >= MinShift && code <= MaxShift) return code;
    return DefaultShift;
  endfunction

endpackage

// ===== src/mcema_state.sv =====
// Per-channel state bank: smoothed value and residue, cleared at reset.
// Depends on mcema_pkg for the read and write-back structs.
module mcema_state #(
  parameter int CHANNELS = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [mcema_pkg::ChanW-1:0] rd_ch_i,
  output mcema_pkg::state_rd_t  rd_o,
  input  mcema_pkg::state_wr_t  wr_i
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [mcema_pkg::ChanW-1:0] ChanLimit = CHANNELS[mcema_pkg::ChanW-1:0];

  mcema_pkg::state_rd_t bank_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < CHANNELS; n++) bank_q[n] <= '0;
    end else if (wr_i.we && wr_i.ch < ChanLimit) begin
      bank_q[wr_i.ch[IdxW-1:0]] <= '{y: wr_i.y, res: wr_i.res};
    end
  end

  always_comb begin
    rd_o = '0;
    if (rd_ch_i < ChanLimit) rd_o = bank_q[rd_ch_i[IdxW-1:0]];
  end

endmodule

// ===== src/mcema_update.sv =====
// Single-pass EMA update: j = y*(2^k-1) + sample + residue, split into j>>k and j mod 2^k.
// Depends on mcema_pkg for widths, the shift lookup and the state structs.
module mcema_update #(
  parameter int CHANNELS = 17
) (
  input  logic                                 vld_i,
  input  logic [mcema_pkg::ChanW-1:0]          ch_i,
  input  logic [mcema_pkg::SampleW-1:0]        sample_i,
  input  logic [mcema_pkg::ShiftTableW-1:0]    shift_table_i,
  input  mcema_pkg::state_rd_t                 cur_i,
  output logic [mcema_pkg::SampleW-1:0]        filtered_o,
  output mcema_pkg::state_wr_t                 wr_o
);

  localparam logic [mcema_pkg::ChanW-1:0] ChanLimit = CHANNELS[mcema_pkg::ChanW-1:0];

  logic                             in_range;
  logic [mcema_pkg::KW-1:0]         k;
  logic [mcema_pkg::ResW-1:0]       frac_mask;
  logic [mcema_pkg::AccW-1:0]       y_ext;
  logic [mcema_pkg::AccW-1:0]       scaled;
  logic [mcema_pkg::AccW-1:0]       acc;
  logic [mcema_pkg::AccW-1:0]       acc_shr;
  logic [mcema_pkg::SampleW-1:0]    y_new;
  logic [mcema_pkg::ResW-1:0]       res_new;

  always_comb begin
    in_range  = ch_i < ChanLimit;
    k         = mcema_pkg::shift_of(shift_table_i, ch_i);
    frac_mask = mcema_pkg::ResW'((6'd1 << k) - 6'd1);
    y_ext     = {{(mcema_pkg::AccW - mcema_pkg::SampleW){1'b0}}, cur_i.y};
    // y*(2^k-1) as a shift and subtract
    scaled    = (y_ext << k) - y_ext;
    acc       = scaled
              + {{(mcema_pkg::AccW - mcema_pkg::SampleW){1'b0}}, sample_i}
              + {{(mcema_pkg::AccW - mcema_pkg::ResW){1'b0}}, cur_i.res};
    acc_shr   = acc >> k;
    y_new     = acc_shr[mcema_pkg::SampleW-1:0];
    res_new   = acc[mcema_pkg::ResW-1:0] & frac_mask;

    filtered_o = in_range ? y_new : '0;
    wr_o.we    = vld_i && in_range;
    wr_o.ch    = ch_i;
    wr_o.y     = y_new;
    wr_o.res   = res_new;
  end

endmodule

// ===== src/multichannel_ema_filter_unit.sv =====
// Top level of the multichannel EMA filter: input register, update logic, result register.
// Depends on mcema_pkg, mcema_state and mcema_update.
//
// Channel   Dir  Handshake                   Contents
// s_axis    in   tvalid/tready               tuser: channel, tdata: sample
// m_axis    out  tvalid/tready               tuser: out_channel, tdata: filtered
// cfg       in   cfg_valid/cfg_ready         shift_table, 3 bits per channel
//
// One item per cycle sustained while m_axis is ready; the item passes the input register, then the result register.
// The channel state is read from the bank in the input stage and written back on the
// same edge that loads the result register, so the next item always sees fresh state.
// Reset clears the state bank at once and loads the default shift table.
// A stalled output holds the result; the input register keeps one more item meanwhile.
module multichannel_ema_filter_unit #(
  parameter int CHANNELS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] sample, [15:12] zero
  input  logic [4:0]  s_axis_tuser_i,   // [4:0] channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] filtered, [15:12] zero
  output logic [4:0]  m_axis_tuser_o,   // [4:0] out_channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [50:0] cfg_data_i
);

  logic                                    in_vld_q;
  logic [mcema_pkg::ChanW-1:0]             in_ch_q;
  logic [mcema_pkg::SampleW-1:0]           in_smp_q;
  logic                                    out_vld_q;
  logic [mcema_pkg::ChanW-1:0]             out_ch_q;
  logic [mcema_pkg::SampleW-1:0]           out_filt_q;
  logic [mcema_pkg::ShiftTableW-1:0]       table_q;

  logic                                    advance;
  logic                                    in_xfer;
  logic [mcema_pkg::SampleW-1:0]           filtered;
  mcema_pkg::state_rd_t                    cur;
  mcema_pkg::state_wr_t                    wr;
  mcema_pkg::state_wr_t                    wr_gated;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q <= mcema_pkg::ShiftTableReset;
    end else if (cfg_valid_i) begin
      table_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_ch_q  <= s_axis_tuser_i;
      in_smp_q <= s_axis_tdata_i[mcema_pkg::SampleW-1:0];
    end
  end

  mcema_state #(
    .CHANNELS(CHANNELS)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_ch_i(in_ch_q),
    .rd_o   (cur),
    .wr_i   (wr_gated)
  );

  mcema_update #(
    .CHANNELS(CHANNELS)
  ) u_update (
    .vld_i        (in_vld_q),
    .ch_i         (in_ch_q),
    .sample_i     (in_smp_q),
    .shift_table_i(table_q),
    .cur_i        (cur),
    .filtered_o   (filtered),
    .wr_o         (wr)
  );

  // Commit state only on the edge that moves the item into the result register
  always_comb begin
    wr_gated    = wr;
    wr_gated.we = wr.we && advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ch_q   <= in_ch_q;
      out_filt_q <= filtered;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_ch_q;
  assign m_axis_tdata_o  = {{(16 - mcema_pkg::SampleW){1'b0}}, out_filt_q};

endmodule
